### rtl/stn_pkg.sv
// Shared constants, codes and the stage-one record for the five-point stencil.
// Used by every design module of the block; no dependencies of its own.
package stn_pkg;

  // Default geometry limits
  localparam int DEF_MAX_LINE    = 1024;
  localparam int DEF_MAX_LINES   = 4096;
  localparam int RST_LINE_LENGTH = 1024;
  localparam int RST_LINE_COUNT  = 1024;
  localparam int SIZE_MIN        = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int LL_FIELD_W = 11;
  localparam int LC_FIELD_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 2'd1;

  // Input kind carried on tuser
  localparam logic ACT_DRAIN = 1'b1;

  // Arithmetic: Q8.8 pixels, Q0.16 weights
  localparam int PIX_W  = 16;
  localparam int SUM_W  = 18;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 33;
  localparam int FRAC_W = 16;
  localparam logic [PIX_W-1:0] W_CENTRE   = 16'd39322;
  localparam logic [PIX_W-1:0] W_SIDE     = 16'd6554;
  localparam int               ROUND_HALF = 32768;

  // Everything the arithmetic needs about one result, besides the two memory reads
  typedef struct packed {
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] down;
    logic             up_m;
    logic             left_m;
    logic             right_m;
    logic             down_m;
    logic             last;
  } s1_t;

endpackage

### rtl/stn_lmem.sv
// Line history memory: one write port, two registered read ports.
// Depends on stn_pkg for the pixel width.
module stn_lmem #(
  parameter int AW = 12
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             wa_i,
  input  logic [stn_pkg::PIX_W-1:0] wd_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             ra_a_i,
  input  logic [AW-1:0]             ra_b_i,
  output logic [stn_pkg::PIX_W-1:0] rd_a_o,
  output logic [stn_pkg::PIX_W-1:0] rd_b_o
);

  localparam int DEPTH = 2 ** AW;

  logic [stn_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [stn_pkg::PIX_W-1:0] rd_a_q;
  logic [stn_pkg::PIX_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
  end

  // Read data holds between reads; the controller relies on that
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_a_q <= mem_q[ra_a_i];
      rd_b_q <= mem_q[ra_b_i];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

### rtl/stn_ctrl.sv
// Stencil controller: geometry registers, stream counters, memory addressing,
// centre/left/down forwarding registers and the stage-one register.
// Depends on stn_pkg.
module stn_ctrl #(
  parameter int MAX_LINE  = stn_pkg::DEF_MAX_LINE,
  parameter int MAX_LINES = stn_pkg::DEF_MAX_LINES,
  parameter int AW        = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_kind_i,
  input  logic [stn_pkg::PIX_W-1:0]      in_pixel_i,
  output logic                           in_ready_o,
  input  logic                           cfg_valid_i,
  input  logic [stn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           cfg_ready_o,
  input  logic [stn_pkg::PIX_W-1:0]      rd_right_i,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_wa_o,
  output logic [stn_pkg::PIX_W-1:0]      mem_wd_o,
  output logic                           mem_re_o,
  output logic [AW-1:0]                  mem_ra_up_o,
  output logic [AW-1:0]                  mem_ra_right_o,
  output logic                           s1_valid_o,
  output stn_pkg::s1_t                   s1_o,
  input  logic                           s2_ready_i
);

  localparam int LLW = $clog2(MAX_LINE + 1);
  localparam int LCW = $clog2(MAX_LINES + 1);
  localparam int CW  = $clog2(MAX_LINE);
  localparam int LNW = $clog2(MAX_LINES);
  localparam int PW  = $clog2(MAX_LINE + 2);
  localparam int LLF = stn_pkg::LL_FIELD_W;
  localparam int LCF = stn_pkg::LC_FIELD_W;
  localparam int LL_RST = (stn_pkg::RST_LINE_LENGTH > MAX_LINE) ? MAX_LINE
                                                                : stn_pkg::RST_LINE_LENGTH;
  localparam int LC_RST = (stn_pkg::RST_LINE_COUNT > MAX_LINES) ? MAX_LINES
                                                                : stn_pkg::RST_LINE_COUNT;

  logic [LLW-1:0] ll_q, ll_d;
  logic [LCW-1:0] lc_q, lc_d;
  logic [PW-1:0]  pend_q, pend_d;
  logic [CW-1:0]  col_q, col_d;
  logic [LNW-1:0] line_q, line_d;
  logic [AW-1:0]  wr_q, wr_d;
  logic [AW-1:0]  cp_q, cp_d;
  logic           cen_mem_q, cen_mem_d;
  logic           s1_valid_q, s1_valid_d;

  logic [stn_pkg::PIX_W-1:0] cen_q, cen_d;
  logic [stn_pkg::PIX_W-1:0] last_px_q, last_px_d;
  stn_pkg::s1_t              s1_q, s1_d;

  logic [LLF-1:0] ll_field;
  logic [LCF-1:0] lc_field;
  logic [LLW-1:0] ll_clamped;
  logic [LCW-1:0] lc_clamped;

  logic is_drain, s1_ready, in_acc, cfg_acc, emit;
  logic pend_full, pend_zero, right_av, down_av, col_end, line_end;

  assign ll_field = cfg_data_i[LLF-1:0];
  assign lc_field = cfg_data_i[LCF-1:0];

  always_comb begin
    if (ll_field < LLF'(stn_pkg::SIZE_MIN)) begin
      ll_clamped = LLW'(stn_pkg::SIZE_MIN);
    end else if (32'(ll_field) > MAX_LINE) begin
      ll_clamped = LLW'(MAX_LINE);
    end else begin
      ll_clamped = LLW'(ll_field);
    end
    if (lc_field < LCF'(stn_pkg::SIZE_MIN)) begin
      lc_clamped = LCW'(stn_pkg::SIZE_MIN);
    end else if (32'(lc_field) > MAX_LINES) begin
      lc_clamped = LCW'(MAX_LINES);
    end else begin
      lc_clamped = LCW'(lc_field);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign is_drain    = (in_kind_i == stn_pkg::ACT_DRAIN);
  assign s1_ready    = !s1_valid_q || s2_ready_i;
  assign in_ready_o  = s1_ready;
  assign in_acc      = in_valid_i && s1_ready;

  // A full window is line_length+1 pending pixels before this one arrives
  assign pend_full = pend_q >= (PW'(ll_q) + PW'(1));
  assign pend_zero = (pend_q == '0);
  assign emit      = in_acc && (is_drain ? !pend_zero : pend_full);
  // On a drain the right and lower neighbours may not have arrived yet
  assign right_av  = !is_drain || (pend_q >= PW'(2));
  assign down_av   = !is_drain || pend_full;
  assign col_end   = (LLW'(col_q) + LLW'(1)) >= ll_q;
  assign line_end  = (LCW'(line_q) + LCW'(1)) >= lc_q;

  always_comb begin
    ll_d       = ll_q;
    lc_d       = lc_q;
    pend_d     = pend_q;
    col_d      = col_q;
    line_d     = line_q;
    wr_d       = wr_q;
    cp_d       = cp_q;
    cen_mem_d  = cen_mem_q;
    cen_d      = cen_q;
    last_px_d  = last_px_q;
    s1_d       = s1_q;
    s1_valid_d = s1_valid_q;

    if (in_acc) begin
      s1_valid_d = emit;
    end else if (s2_ready_i) begin
      s1_valid_d = 1'b0;
    end

    if (cfg_acc) begin
      unique case (cfg_index_i)
        stn_pkg::CFG_LINE_LENGTH: ll_d = ll_clamped;
        stn_pkg::CFG_LINE_COUNT:  lc_d = lc_clamped;
        default: ;
      endcase
      // Start a new grid; the history stays, edge masking hides it
      pend_d    = '0;
      col_d     = '0;
      line_d    = '0;
      cp_d      = wr_q;
      cen_mem_d = 1'b0;
    end else if (in_acc) begin
      if (!is_drain) begin
        wr_d      = wr_q + AW'(1);
        last_px_d = in_pixel_i;
        if (pend_zero) begin
          // This pixel is the next centre
          cen_d     = in_pixel_i;
          cen_mem_d = 1'b0;
        end
      end
      if (emit) begin
        s1_d.centre  = cen_mem_q ? rd_right_i : cen_q;
        s1_d.left    = s1_q.centre;
        s1_d.down    = last_px_q;
        s1_d.up_m    = (line_q != '0);
        s1_d.left_m  = (col_q != '0);
        s1_d.right_m = !col_end && right_av;
        s1_d.down_m  = !line_end && down_av;
        s1_d.last    = col_end && line_end;
        cp_d         = cp_q + AW'(1);
        // The right read of this result is the centre of the next one
        cen_mem_d    = right_av;
        if (col_end) begin
          col_d  = '0;
          line_d = line_end ? '0 : line_q + LNW'(1);
        end else begin
          col_d  = col_q + CW'(1);
        end
      end
      if (!is_drain && !emit) begin
        pend_d = pend_q + PW'(1);
      end else if (is_drain && emit) begin
        pend_d = pend_q - PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ll_q       <= LLW'(LL_RST);
      lc_q       <= LCW'(LC_RST);
      pend_q     <= '0;
      col_q      <= '0;
      line_q     <= '0;
      wr_q       <= '0;
      cp_q       <= '0;
      cen_mem_q  <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      ll_q       <= ll_d;
      lc_q       <= lc_d;
      pend_q     <= pend_d;
      col_q      <= col_d;
      line_q     <= line_d;
      wr_q       <= wr_d;
      cp_q       <= cp_d;
      cen_mem_q  <= cen_mem_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cen_q     <= cen_d;
    last_px_q <= last_px_d;
    s1_q      <= s1_d;
  end

  assign mem_we_o       = in_acc && !is_drain && !cfg_acc;
  assign mem_wa_o       = wr_q;
  assign mem_wd_o       = in_pixel_i;
  assign mem_re_o       = emit && !cfg_acc;
  assign mem_ra_up_o    = cp_q - AW'(ll_q);
  assign mem_ra_right_o = cp_q + AW'(1);
  assign s1_valid_o     = s1_valid_q;
  assign s1_o           = s1_q;

endmodule

### rtl/stn_mac.sv
// Stencil arithmetic: neighbour masking and sum, weight multiplies, rounding,
// saturation and the output register, with a per-stage valid/ready chain.
// Depends on stn_pkg.
module stn_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s1_valid_i,
  input  stn_pkg::s1_t              s1_i,
  input  logic [stn_pkg::PIX_W-1:0] rd_up_i,
  input  logic [stn_pkg::PIX_W-1:0] rd_right_i,
  output logic                      s2_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [stn_pkg::PIX_W-1:0] out_data_o,
  output logic                      out_last_o
);

  localparam int PIXW  = stn_pkg::PIX_W;
  localparam int SUMW  = stn_pkg::SUM_W;
  localparam int PRODW = stn_pkg::PROD_W;
  localparam int ACCW  = stn_pkg::ACC_W;
  localparam int FRACW = stn_pkg::FRAC_W;

  logic v2_q, v3_q, v4_q;
  logic s3_ready, s4_ready;

  logic [PIXW-1:0]  c2_q;
  logic [SUMW-1:0]  sum2_q, sum2_d;
  logic             last2_q, last3_q, last4_q;
  logic [PRODW-1:0] pc3_q, ps3_q;
  logic [PIXW-1:0]  res4_q, res4_d;
  logic [ACCW-1:0]  acc;
  logic [ACCW-FRACW-1:0] rnd;

  assign s4_ready   = !v4_q || out_ready_i;
  assign s3_ready   = !v3_q || s4_ready;
  assign s2_ready_o = !v2_q || s3_ready;

  always_comb begin
    sum2_d = (s1_i.up_m    ? SUMW'(rd_up_i)    : '0)
           + (s1_i.left_m  ? SUMW'(s1_i.left)  : '0)
           + (s1_i.right_m ? SUMW'(rd_right_i) : '0)
           + (s1_i.down_m  ? SUMW'(s1_i.down)  : '0);
  end

  // Round half up, then saturate
  assign acc    = ACCW'(pc3_q) + ACCW'(ps3_q) + ACCW'(stn_pkg::ROUND_HALF);
  assign rnd    = acc[ACCW-1:FRACW];
  assign res4_d = rnd[ACCW-FRACW-1] ? '1 : rnd[PIXW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (s2_ready_o) v2_q <= s1_valid_i;
      if (s3_ready)   v3_q <= v2_q;
      if (s4_ready)   v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready_o && s1_valid_i) begin
      c2_q    <= s1_i.centre;
      sum2_q  <= sum2_d;
      last2_q <= s1_i.last;
    end
    if (s3_ready && v2_q) begin
      pc3_q   <= PRODW'(c2_q) * PRODW'(stn_pkg::W_CENTRE);
      ps3_q   <= PRODW'(sum2_q) * PRODW'(stn_pkg::W_SIDE);
      last3_q <= last2_q;
    end
    if (s4_ready && v3_q) begin
      res4_q  <= res4_d;
      last4_q <= last3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = res4_q;
  assign out_last_o  = last4_q;

endmodule

### rtl/five_point_weighted_stencil_top.sv
// Top level of the five-point weighted stencil: controller, line memory and
// arithmetic pipeline. Depends on stn_pkg, stn_ctrl, stn_lmem and stn_mac.
//
//   channel  direction  handshake              payload
//   s_axis   in         tvalid / tready        tdata = pixel, tuser = action
//   m_axis   out        tvalid / tready        tdata = filtered, tlast = last_of_frame
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle on both streams while m_axis is not stalled. A result
// moves from the stage-one register through the sum, product and output registers
// to m_axis; the line memory serves one write and two reads per cycle. Reset clears
// counters and valid bits and loads the default geometry; no memory sweep. Each
// pipeline stage moves when the stage ahead is free, so empty stages absorb output stalls.
module five_point_weighted_stencil_top #(
  parameter int MAX_LINE  = stn_pkg::DEF_MAX_LINE,
  parameter int MAX_LINES = stn_pkg::DEF_MAX_LINES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // [15:0] pixel
  input  logic                           s_axis_tuser,  // [0] action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // [15:0] filtered
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [stn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stn_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(2 * MAX_LINE + 2);

  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_wa, mem_ra_up, mem_ra_right;
  logic [stn_pkg::PIX_W-1:0] mem_wd, rd_up, rd_right;
  logic                      s1_valid, s2_ready;
  stn_pkg::s1_t              s1;

  stn_ctrl #(
    .MAX_LINE  (MAX_LINE),
    .MAX_LINES (MAX_LINES),
    .AW        (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_kind_i      (s_axis_tuser),
    .in_pixel_i     (s_axis_tdata),
    .in_ready_o     (s_axis_tready),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .rd_right_i     (rd_right),
    .mem_we_o       (mem_we),
    .mem_wa_o       (mem_wa),
    .mem_wd_o       (mem_wd),
    .mem_re_o       (mem_re),
    .mem_ra_up_o    (mem_ra_up),
    .mem_ra_right_o (mem_ra_right),
    .s1_valid_o     (s1_valid),
    .s1_o           (s1),
    .s2_ready_i     (s2_ready)
  );

  stn_lmem #(
    .AW (AW)
  ) u_lmem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .wa_i   (mem_wa),
    .wd_i   (mem_wd),
    .re_i   (mem_re),
    .ra_a_i (mem_ra_up),
    .ra_b_i (mem_ra_right),
    .rd_a_o (rd_up),
    .rd_b_o (rd_right)
  );

  stn_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_i        (s1),
    .rd_up_i     (rd_up),
    .rd_right_i  (rd_right),
    .s2_ready_o  (s2_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### rtl/stn_chk.sv
// Port-level checks for the five-point stencil top, attached by bind.
// Depends on five_point_weighted_stencil_top.
module stn_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output transaction changed");

  // An empty output register means every stage behind it can advance
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register empty");

  // A fresh result must come from an input transaction that passed the stage-one, sum, product and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 4))
    else $error("output appeared without matching input transaction");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind five_point_weighted_stencil_top stn_chk u_stn_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
